// ----- design/ltc_pkg.sv -----
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types, constants and helpers for the lexer token classifier.
// ----------------------------------------------------------------------------
package ltc_pkg;

  localparam int SET_SIZE   = 8;
  localparam int CHAR_BITS  = 8;
  localparam int LIST_W     = SET_SIZE * CHAR_BITS;
  localparam int CNT_W      = 4;
  localparam int CFG_DATA_W = LIST_W;
  localparam int CFG_IDX_W  = 4;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // Character codes
  localparam logic [CHAR_BITS-1:0] CH_ZERO    = CHAR_BITS'(48);
  localparam logic [CHAR_BITS-1:0] CH_NINE    = CHAR_BITS'(57);
  localparam logic [CHAR_BITS-1:0] CH_DOT     = CHAR_BITS'(46);
  localparam logic [CHAR_BITS-1:0] CH_UPPER_A = CHAR_BITS'(65);
  localparam logic [CHAR_BITS-1:0] CH_UPPER_Z = CHAR_BITS'(90);
  localparam logic [CHAR_BITS-1:0] CH_LOWER_A = CHAR_BITS'(97);
  localparam logic [CHAR_BITS-1:0] CH_LOWER_Z = CHAR_BITS'(122);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEP_LIST = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SEP_CNT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_NEU_LIST = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_NEU_CNT  = CFG_IDX_W'(3);

  // Token type codes
  localparam logic [1:0] TYPE_INT   = 2'd0;
  localparam logic [1:0] TYPE_FLOAT = 2'd1;
  localparam logic [1:0] TYPE_STR   = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_INT,
    KIND_FLOAT,
    KIND_STR
  } kind_t;

  typedef struct packed {
    logic [LIST_W-1:0] sep_list;
    logic [CNT_W-1:0]  sep_cnt;
    logic [LIST_W-1:0] neu_list;
    logic [CNT_W-1:0]  neu_cnt;
  } cfg_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] ch;
    logic                 char_valid;
    logic [1:0]           token_type;
    logic                 token_start;
    logic                 token_end;
    logic                 last_of_run;
  } rslt_t;

  typedef struct packed {
    rslt_t      first;
    rslt_t      second;
    logic [1:0] count;
  } cls_out_t;

  function automatic logic [1:0] type_of(kind_t kind);
    logic [1:0] t;
    case (kind)
      KIND_INT:   t = TYPE_INT;
      KIND_FLOAT: t = TYPE_FLOAT;
      default:    t = TYPE_STR;
    endcase
    return t;
  endfunction

  function automatic logic in_set(logic [LIST_W-1:0] list, logic [CNT_W-1:0] cnt,
                                  logic [CHAR_BITS-1:0] ch);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < SET_SIZE; i++) begin
      if ((CNT_W'(i) < cnt) && (list[i*CHAR_BITS +: CHAR_BITS] == ch)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ----- design/lexer_token_classifier_top.sv -----
// ----------------------------------------------------------------------------
// lexer_token_classifier_top
// Character-stream tokenizer tag stage with configurable separator and
// neutral-letter sets.
// ----------------------------------------------------------------------------
// One character request is taken per clock while in_ready is high. Each
// character is classified in the accept cycle against the open token
// (integer, float, string or none) and produces zero, one or two result
// records, written into a four-entry result queue; out_ drains it one record
// per clock while out_ready is high. A character that closes a token and
// starts another yields an end marker followed by its own record. Throughput
// is one character per cycle while each gives at most one record, and is
// bounded by the single queue read port otherwise. in_ready is high whenever
// the queue has room for two records, so the input side never waits on a
// merely pending result. Configuration registers are written through cfg_;
// the user must do so only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module lexer_token_classifier_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // character requests
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ltc_pkg::CHAR_BITS-1:0]  in_char,
  input  logic                           in_last,
  // tagged results
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ltc_pkg::CHAR_BITS-1:0]  out_char,
  output logic                           out_char_valid,
  output logic [1:0]                     out_token_type,
  output logic                           out_token_start,
  output logic                           out_token_end,
  output logic                           out_last_of_run,
  // configuration writes
  input  logic                           cfg_wr_en,
  input  logic [ltc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ltc_pkg::CFG_DATA_W-1:0] cfg_data
);

  ltc_pkg::cfg_t     cfg_r, cfg_nxt;
  ltc_pkg::kind_t    open_kind_r, open_kind_nxt;
  ltc_pkg::kind_t    cls_kind;
  ltc_pkg::cls_out_t cls;
  ltc_pkg::rslt_t    head;
  logic              accept;
  logic              room2;
  logic              not_empty;
  logic [1:0]        push_cnt;

  // Register file: unknown indexes are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        ltc_pkg::REG_SEP_LIST: cfg_nxt.sep_list = cfg_data[ltc_pkg::LIST_W-1:0];
        ltc_pkg::REG_SEP_CNT:  cfg_nxt.sep_cnt  = cfg_data[ltc_pkg::CNT_W-1:0];
        ltc_pkg::REG_NEU_LIST: cfg_nxt.neu_list = cfg_data[ltc_pkg::LIST_W-1:0];
        ltc_pkg::REG_NEU_CNT:  cfg_nxt.neu_cnt  = cfg_data[ltc_pkg::CNT_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Classify the incoming character against the open token
  ltc_classifier u_classifier (
    .ch        (in_char),
    .last      (in_last),
    .open_kind (open_kind_r),
    .cfg       (cfg_r),
    .cls       (cls),
    .kind_nxt  (cls_kind)
  );

  assign in_ready = room2;
  assign accept   = in_valid && in_ready;
  assign push_cnt = accept ? cls.count : 2'd0;

  // Advance the open-token state only on an accepted request
  always_comb begin
    open_kind_nxt = accept ? cls_kind : open_kind_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_kind_r <= ltc_pkg::KIND_NONE;
    end else begin
      open_kind_r <= open_kind_nxt;
    end
  end

  // Hold results until the consumer takes them
  ltc_rslt_fifo u_rslt_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_a    (cls.first),
    .push_b    (cls.second),
    .pop       (out_ready),
    .head      (head),
    .not_empty (not_empty),
    .room2     (room2)
  );

  assign out_valid       = not_empty;
  assign out_char        = head.ch;
  assign out_char_valid  = head.char_valid;
  assign out_token_type  = head.token_type;
  assign out_token_start = head.token_start;
  assign out_token_end   = head.token_end;
  assign out_last_of_run = head.last_of_run;

  // The last character of the text always leaves no token open
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> (open_kind_r == ltc_pkg::KIND_NONE))
    else $error("token left open after last character");

  // A request that yields a result makes output valid in the next cycle
  a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (cls.count != 2'd0)) |=> out_valid)
    else $error("accepted result not presented");

  // A two-record run always starts with a pure end marker
  a_two_starts_with_end: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (cls.count == 2'd2)) |-> (!cls.first.char_valid && cls.first.token_end))
    else $error("two-record run without leading end marker");

endmodule

// ----- design/ltc_classifier.sv -----
// ----------------------------------------------------------------------------
// ltc_classifier
// Classifies one character against the open token and builds up to two
// result records plus the next open-token kind.
// ----------------------------------------------------------------------------
module ltc_classifier (
  input  logic [ltc_pkg::CHAR_BITS-1:0] ch,
  input  logic                          last,
  input  ltc_pkg::kind_t                open_kind,
  input  ltc_pkg::cfg_t                 cfg,
  output ltc_pkg::cls_out_t             cls,
  output ltc_pkg::kind_t                kind_nxt
);

  logic is_digit, is_dot, is_numeric, is_alpha, is_sep;
  logic cont;
  ltc_pkg::kind_t cont_kind;
  ltc_pkg::kind_t start_kind;
  logic start_hit;
  logic [1:0] start_type;

  always_comb begin
    is_digit   = (ch >= ltc_pkg::CH_ZERO) && (ch <= ltc_pkg::CH_NINE);
    is_dot     = (ch == ltc_pkg::CH_DOT);
    is_numeric = is_digit || is_dot;
    is_alpha   = ((ch >= ltc_pkg::CH_UPPER_A) && (ch <= ltc_pkg::CH_UPPER_Z)) ||
                 ((ch >= ltc_pkg::CH_LOWER_A) && (ch <= ltc_pkg::CH_LOWER_Z)) ||
                 ltc_pkg::in_set(cfg.neu_list, cfg.neu_cnt, ch);
    is_sep     = ltc_pkg::in_set(cfg.sep_list, cfg.sep_cnt, ch);

    cont = (open_kind == ltc_pkg::KIND_STR) ? (is_alpha || is_numeric) :
           (open_kind != ltc_pkg::KIND_NONE) ? is_numeric : 1'b0;
    cont_kind = ((open_kind == ltc_pkg::KIND_INT) && is_dot) ? ltc_pkg::KIND_FLOAT
                                                             : open_kind;

    // Separator wins over every other class at token start
    start_hit  = is_sep || is_numeric || is_alpha;
    if (is_sep) begin
      start_kind = ltc_pkg::KIND_NONE;
      start_type = ltc_pkg::TYPE_STR;
    end else if (is_numeric) begin
      start_kind = is_dot ? ltc_pkg::KIND_FLOAT : ltc_pkg::KIND_INT;
      start_type = is_dot ? ltc_pkg::TYPE_FLOAT : ltc_pkg::TYPE_INT;
    end else if (is_alpha) begin
      start_kind = ltc_pkg::KIND_STR;
      start_type = ltc_pkg::TYPE_STR;
    end else begin
      start_kind = ltc_pkg::KIND_NONE;
      start_type = ltc_pkg::TYPE_STR;
    end
  end

  // Next open-token kind
  always_comb begin
    if (cont) begin
      kind_nxt = last ? ltc_pkg::KIND_NONE : cont_kind;
    end else begin
      kind_nxt = last ? ltc_pkg::KIND_NONE : start_kind;
    end
  end

  // Result records
  always_comb begin
    ltc_pkg::rslt_t end_mark;
    ltc_pkg::rslt_t start_rec;
    ltc_pkg::rslt_t cont_rec;

    end_mark.ch          = '0;
    end_mark.char_valid  = 1'b0;
    end_mark.token_type  = ltc_pkg::type_of(open_kind);
    end_mark.token_start = 1'b0;
    end_mark.token_end   = 1'b1;
    end_mark.last_of_run = !start_hit;

    start_rec.ch          = ch;
    start_rec.char_valid  = 1'b1;
    start_rec.token_type  = start_type;
    start_rec.token_start = 1'b1;
    start_rec.token_end   = is_sep || last;
    start_rec.last_of_run = 1'b1;

    cont_rec.ch          = ch;
    cont_rec.char_valid  = 1'b1;
    cont_rec.token_type  = ltc_pkg::type_of(cont_kind);
    cont_rec.token_start = 1'b0;
    cont_rec.token_end   = last;
    cont_rec.last_of_run = 1'b1;

    cls.second = start_rec;
    if (cont) begin
      cls.first = cont_rec;
      cls.count = 2'd1;
    end else if (open_kind != ltc_pkg::KIND_NONE) begin
      cls.first = end_mark;
      cls.count = start_hit ? 2'd2 : 2'd1;
    end else begin
      cls.first = start_rec;
      cls.count = start_hit ? 2'd1 : 2'd0;
    end
  end

endmodule

// ----- design/ltc_rslt_fifo.sv -----
// ----------------------------------------------------------------------------
// ltc_rslt_fifo
// Small result queue: takes up to two records per cycle, hands out one.
// ----------------------------------------------------------------------------
module ltc_rslt_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [1:0]                 push_cnt,
  input  ltc_pkg::rslt_t             push_a,
  input  ltc_pkg::rslt_t             push_b,
  input  logic                       pop,
  output ltc_pkg::rslt_t             head,
  output logic                       not_empty,
  output logic                       room2
);

  ltc_pkg::rslt_t mem [ltc_pkg::FIFO_DEPTH];

  logic [ltc_pkg::PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [ltc_pkg::PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [ltc_pkg::FCNT_W-1:0] cnt_r, cnt_nxt;
  logic [ltc_pkg::PTR_W-1:0]  wr_ptr_b;
  logic                       do_pop;

  always_comb begin
    do_pop     = pop && (cnt_r != '0);
    wr_ptr_b   = wr_ptr_r + ltc_pkg::PTR_W'(1);
    wr_ptr_nxt = wr_ptr_r + ltc_pkg::PTR_W'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + ltc_pkg::PTR_W'(do_pop);
    cnt_nxt    = cnt_r + ltc_pkg::FCNT_W'(push_cnt) - ltc_pkg::FCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_b] <= push_b;
    end
  end

  assign head      = mem[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= ltc_pkg::FCNT_W'(ltc_pkg::FIFO_DEPTH - 2));

endmodule
